/* hdl/jts_pkg.sv */
// Shared types, codes and literal tables for the JSON token scanner.
// Used by jts_ctrl, jts_datapath and json_token_scanner_unit; depends on nothing.
package jts_pkg;

  // One text byte as it arrives on the input channel.
  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } in_word_t;

  // One token as it leaves on the output channel.
  typedef struct packed {
    logic [3:0]  token_type;
    logic [15:0] token_start;
    logic [15:0] token_length;
    logic        token_last;
  } out_word_t;

  localparam logic [3:0] TT_LBRACE   = 4'd0;
  localparam logic [3:0] TT_RBRACE   = 4'd1;
  localparam logic [3:0] TT_LBRACKET = 4'd2;
  localparam logic [3:0] TT_RBRACKET = 4'd3;
  localparam logic [3:0] TT_COLON    = 4'd4;
  localparam logic [3:0] TT_COMMA    = 4'd5;
  localparam logic [3:0] TT_STRING   = 4'd6;
  localparam logic [3:0] TT_NUMBER   = 4'd7;
  localparam logic [3:0] TT_TRUE     = 4'd8;
  localparam logic [3:0] TT_EOF      = 4'd11;
  localparam logic [3:0] TT_ERROR    = 4'd12;

  localparam logic [1:0] KIND_TRUE  = 2'd0;
  localparam logic [1:0] KIND_FALSE = 2'd1;
  localparam logic [1:0] KIND_NULL  = 2'd2;

  // Operations that the controller hands to the datapath.
  typedef enum logic [2:0] {
    CMD_NONE,
    CMD_LATCH,
    CMD_MODE,
    CMD_SCAN_BYTE,
    CMD_SCAN_BUF,
    CMD_FLUSH,
    CMD_EOF,
    CMD_DONE
  } cmd_t;

  typedef struct packed {
    logic hold;        // a token is parked and the output register cannot take it
    logic need_scan;   // the current byte must still be scanned from idle
    logic fail_start;  // a literal mismatch has begun
    logic fail_more;   // more buffered literal bytes remain to rescan
    logic last;        // the byte at hand ends the text
  } status_t;

  function automatic logic [7:0] lit_char(input logic [1:0] kind, input logic [2:0] idx);
    logic [7:0] ch;
    ch = 8'h00;
    case (kind)
      KIND_FALSE: begin
        case (idx)
          3'd0: ch = 8'h66;
          3'd1: ch = 8'h61;
          3'd2: ch = 8'h6C;
          3'd3: ch = 8'h73;
          3'd4: ch = 8'h65;
          default: ch = 8'h00;
        endcase
      end
      KIND_NULL: begin
        case (idx)
          3'd0: ch = 8'h6E;
          3'd1: ch = 8'h75;
          3'd2: ch = 8'h6C;
          3'd3: ch = 8'h6C;
          default: ch = 8'h00;
        endcase
      end
      default: begin
        case (idx)
          3'd0: ch = 8'h74;
          3'd1: ch = 8'h72;
          3'd2: ch = 8'h75;
          3'd3: ch = 8'h65;
          default: ch = 8'h00;
        endcase
      end
    endcase
    return ch;
  endfunction

  function automatic logic [2:0] lit_len(input logic [1:0] kind);
    return (kind == KIND_FALSE) ? 3'd5 : 3'd4;
  endfunction

endpackage

/* hdl/jts_ctrl.sv */
// Sequencer of the JSON token scanner: walks each byte through its scan steps.
// Depends on jts_pkg; drives the command input of jts_datapath.
module jts_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              byte_valid,
  output logic              byte_ready,
  input  jts_pkg::status_t  status,
  output jts_pkg::cmd_t     cmd
);

  typedef enum logic [6:0] {
    ST_WAIT = 7'b0000001,
    ST_MODE = 7'b0000010,
    ST_FAIL = 7'b0000100,
    ST_SCAN = 7'b0001000,
    ST_LAST = 7'b0010000,
    ST_EOF  = 7'b0100000,
    ST_DONE = 7'b1000000
  } state_t;

  state_t state, state_next;
  logic   fail_to_eof, fail_to_eof_next;

  always_comb begin
    state_next       = state;
    fail_to_eof_next = fail_to_eof;
    cmd              = jts_pkg::CMD_NONE;
    case (state)
      ST_WAIT: begin
        if (byte_valid) begin
          cmd        = jts_pkg::CMD_LATCH;
          state_next = ST_MODE;
        end
      end
      ST_MODE: begin
        if (!status.hold) begin
          cmd = jts_pkg::CMD_MODE;
          if (status.fail_start) begin
            fail_to_eof_next = 1'b0;
            state_next       = status.fail_more ? ST_FAIL : ST_SCAN;
          end else if (status.need_scan) begin
            state_next = ST_SCAN;
          end else begin
            state_next = ST_LAST;
          end
        end
      end
      ST_FAIL: begin
        if (!status.hold) begin
          cmd = jts_pkg::CMD_SCAN_BUF;
          if (!status.fail_more) begin
            state_next = fail_to_eof ? ST_EOF : ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (!status.hold) begin
          cmd        = jts_pkg::CMD_SCAN_BYTE;
          state_next = ST_LAST;
        end
      end
      ST_LAST: begin
        if (!status.last) begin
          state_next = ST_DONE;
        end else if (!status.hold) begin
          cmd = jts_pkg::CMD_FLUSH;
          if (status.fail_start) begin
            fail_to_eof_next = 1'b1;
            state_next       = status.fail_more ? ST_FAIL : ST_EOF;
          end else begin
            state_next = ST_EOF;
          end
        end
      end
      ST_EOF: begin
        if (!status.hold) begin
          cmd        = jts_pkg::CMD_EOF;
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!status.hold) begin
          cmd        = jts_pkg::CMD_DONE;
          state_next = ST_WAIT;
        end
      end
      default: begin
        state_next = ST_WAIT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_WAIT;
      fail_to_eof <= 1'b0;
    end else begin
      state       <= state_next;
      fail_to_eof <= fail_to_eof_next;
    end
  end

  assign byte_ready = (state == ST_WAIT);

endmodule

/* hdl/jts_datapath.sv */
// Datapath of the JSON token scanner: scan state, literal buffer, token staging.
// Depends on jts_pkg; executes the commands issued by jts_ctrl.
module jts_datapath #(
  parameter int MAX_TEXT_BYTES
) (
  input  logic                clk,
  input  logic                rst,
  input  jts_pkg::cmd_t       cmd,
  output jts_pkg::status_t    status,
  input  jts_pkg::in_word_t   byte_data,
  output logic                token_valid,
  input  logic                token_ready,
  output jts_pkg::out_word_t  token_data
);

  localparam int OW = $clog2(MAX_TEXT_BYTES);
  localparam logic [OW:0]   MAX_W  = (OW + 1)'(MAX_TEXT_BYTES);
  localparam logic [OW-1:0] POS_TOP = OW'(MAX_TEXT_BYTES - 1);

  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_LBRKT  = 8'h5B;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_RBRKT  = 8'h5D;
  localparam logic [7:0] CH_F      = 8'h66;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;

  typedef enum logic [3:0] {
    MODE_IDLE    = 4'b0001,
    MODE_STRING  = 4'b0010,
    MODE_NUMBER  = 4'b0100,
    MODE_LITERAL = 4'b1000
  } scan_mode_t;

  function automatic logic [OW-1:0] wrap_inc(input logic [OW-1:0] p);
    return (p == POS_TOP) ? '0 : p + OW'(1);
  endfunction

  function automatic logic [OW-1:0] wrap_add(input logic [OW-1:0] b, input logic [1:0] i);
    logic [OW:0] s;
    s = {1'b0, b} + (OW + 1)'(i);
    if (s >= MAX_W) s = s - MAX_W;
    return s[OW-1:0];
  endfunction

  function automatic logic [15:0] to_start(input logic [OW-1:0] p);
    logic [OW+15:0] e;
    e = {16'b0, p};
    return e[15:0];
  endfunction

  // Scan state.
  scan_mode_t       mode, mode_next;
  logic             esc, esc_next;
  logic             frac, frac_next;
  logic [OW-1:0]    byte_offset, offset_next;
  logic [OW-1:0]    token_begin, begin_next;
  logic [15:0]      tok_len, len_next;
  logic [1:0]       lit_kind, kind_next;
  logic [2:0]       lit_cnt, cnt_next;
  logic [7:0]       lit_buf [4];
  logic             buf_we;
  logic [1:0]       buf_waddr;
  logic [7:0]       buf_wdata;

  // Byte at hand and literal rescan bookkeeping.
  logic [7:0]       c_reg, c_next;
  logic             last_reg, last_next;
  logic [OW-1:0]    pos, pos_next;
  logic [OW-1:0]    fail_base, fail_base_next;
  logic [2:0]       fail_cnt, fail_cnt_next;
  logic [1:0]       fail_idx, fail_idx_next;

  // Token staging: one parked word so that the last word of a byte can be flagged.
  jts_pkg::out_word_t pend;
  logic               pend_valid;
  jts_pkg::out_word_t tok;
  logic               tok_emit;
  logic               release_pend;

  logic [7:0]       scan_byte;
  logic [OW-1:0]    scan_pos;
  logic [OW-1:0]    fail_pos;
  logic             do_scan;
  logic             need_scan, fail_start, fail_more;
  logic [15:0]      len_inc;
  logic [1:0]       k_eff;
  logic             lit_match;
  logic             out_free;

  assign fail_pos  = wrap_add(fail_base, fail_idx);
  assign scan_byte = (cmd == jts_pkg::CMD_SCAN_BUF) ? lit_buf[fail_idx] : c_reg;
  assign scan_pos  = (cmd == jts_pkg::CMD_SCAN_BUF) ? fail_pos : pos;
  assign len_inc   = (tok_len == 16'hFFFF) ? tok_len : tok_len + 16'd1;
  assign k_eff     = (lit_kind == 2'd3) ? jts_pkg::KIND_TRUE : lit_kind;
  assign lit_match = (lit_cnt < jts_pkg::lit_len(k_eff)) &&
                     (c_reg == jts_pkg::lit_char(k_eff, lit_cnt));

  always_comb begin
    mode_next      = mode;
    esc_next       = esc;
    frac_next      = frac;
    offset_next    = byte_offset;
    begin_next     = token_begin;
    len_next       = tok_len;
    kind_next      = lit_kind;
    cnt_next       = lit_cnt;
    buf_we         = 1'b0;
    buf_waddr      = lit_cnt[1:0];
    buf_wdata      = c_reg;
    c_next         = c_reg;
    last_next      = last_reg;
    pos_next       = pos;
    fail_base_next = fail_base;
    fail_cnt_next  = fail_cnt;
    fail_idx_next  = fail_idx;
    tok            = '0;
    tok_emit       = 1'b0;
    release_pend   = 1'b0;
    do_scan        = 1'b0;
    need_scan      = 1'b0;
    fail_start     = 1'b0;
    fail_more      = 1'b0;

    case (cmd)
      jts_pkg::CMD_LATCH: begin
        c_next    = byte_data.in_byte;
        last_next = byte_data.in_last;
        pos_next  = byte_offset;
      end
      jts_pkg::CMD_MODE: begin
        case (mode)
          MODE_STRING: begin
            if (esc) begin
              esc_next = 1'b0;
              len_next = len_inc;
            end else if (c_reg == CH_BSLASH) begin
              esc_next = 1'b1;
              len_next = len_inc;
            end else if (c_reg == CH_QUOTE) begin
              tok_emit           = 1'b1;
              tok.token_type     = jts_pkg::TT_STRING;
              tok.token_start    = to_start(token_begin);
              tok.token_length   = tok_len;
              mode_next          = MODE_IDLE;
            end else begin
              len_next = len_inc;
            end
          end
          MODE_NUMBER: begin
            if (c_reg >= CH_ZERO && c_reg <= CH_NINE) begin
              len_next = len_inc;
            end else if (c_reg == CH_DOT && !frac) begin
              frac_next = 1'b1;
              len_next  = len_inc;
            end else begin
              tok_emit         = 1'b1;
              tok.token_type   = jts_pkg::TT_NUMBER;
              tok.token_start  = to_start(token_begin);
              tok.token_length = tok_len;
              mode_next        = MODE_IDLE;
              need_scan        = 1'b1;
            end
          end
          MODE_LITERAL: begin
            if (lit_match) begin
              if ((lit_cnt + 3'd1) == jts_pkg::lit_len(k_eff)) begin
                tok_emit         = 1'b1;
                tok.token_type   = jts_pkg::TT_TRUE + {2'b00, k_eff};
                tok.token_start  = to_start(token_begin);
                tok.token_length = {13'd0, jts_pkg::lit_len(k_eff)};
                mode_next        = MODE_IDLE;
                cnt_next         = 3'd0;
              end else begin
                buf_we    = 1'b1;
                buf_waddr = lit_cnt[1:0];
                buf_wdata = c_reg;
                cnt_next  = lit_cnt + 3'd1;
              end
            end else begin
              // Mismatch: error at the literal's first byte, rest is rescanned.
              tok_emit        = 1'b1;
              tok.token_type  = jts_pkg::TT_ERROR;
              tok.token_start = to_start(token_begin);
              mode_next       = MODE_IDLE;
              cnt_next        = 3'd0;
              fail_base_next  = token_begin;
              fail_cnt_next   = lit_cnt;
              fail_idx_next   = 2'd1;
              fail_start      = 1'b1;
              fail_more       = (lit_cnt > 3'd1);
              need_scan       = 1'b1;
            end
          end
          default: begin
            mode_next = MODE_IDLE;
            do_scan   = 1'b1;
          end
        endcase
      end
      jts_pkg::CMD_SCAN_BYTE: begin
        do_scan = 1'b1;
      end
      jts_pkg::CMD_SCAN_BUF: begin
        do_scan       = 1'b1;
        fail_idx_next = fail_idx + 2'd1;
        fail_more     = (({1'b0, fail_idx} + 3'd1) < fail_cnt);
      end
      jts_pkg::CMD_FLUSH: begin
        case (mode)
          MODE_STRING: begin
            tok_emit         = 1'b1;
            tok.token_type   = jts_pkg::TT_STRING;
            tok.token_start  = to_start(token_begin);
            tok.token_length = tok_len;
          end
          MODE_NUMBER: begin
            tok_emit         = 1'b1;
            tok.token_type   = jts_pkg::TT_NUMBER;
            tok.token_start  = to_start(token_begin);
            tok.token_length = tok_len;
          end
          MODE_LITERAL: begin
            tok_emit        = 1'b1;
            tok.token_type  = jts_pkg::TT_ERROR;
            tok.token_start = to_start(token_begin);
            cnt_next        = 3'd0;
            fail_base_next  = token_begin;
            fail_cnt_next   = lit_cnt;
            fail_idx_next   = 2'd1;
            fail_start      = 1'b1;
            fail_more       = (lit_cnt > 3'd1);
          end
          default: begin
          end
        endcase
        mode_next = MODE_IDLE;
      end
      jts_pkg::CMD_EOF: begin
        tok_emit        = 1'b1;
        tok.token_type  = jts_pkg::TT_EOF;
        tok.token_start = to_start(wrap_inc(pos));
        mode_next       = MODE_IDLE;
        esc_next        = 1'b0;
        frac_next       = 1'b0;
        cnt_next        = 3'd0;
      end
      jts_pkg::CMD_DONE: begin
        offset_next  = last_reg ? '0 : wrap_inc(pos);
        release_pend = 1'b1;
      end
      default: begin
      end
    endcase

    // Scan of one byte from idle: the current byte or a rescanned literal byte.
    if (do_scan) begin
      case (scan_byte)
        CH_SPACE, CH_TAB, CH_CR, CH_LF: begin
        end
        CH_LBRACE, CH_RBRACE, CH_LBRKT, CH_RBRKT, CH_COLON, CH_COMMA: begin
          tok_emit         = 1'b1;
          tok.token_start  = to_start(scan_pos);
          tok.token_length = 16'd1;
          case (scan_byte)
            CH_LBRACE: tok.token_type = jts_pkg::TT_LBRACE;
            CH_RBRACE: tok.token_type = jts_pkg::TT_RBRACE;
            CH_LBRKT:  tok.token_type = jts_pkg::TT_LBRACKET;
            CH_RBRKT:  tok.token_type = jts_pkg::TT_RBRACKET;
            CH_COLON:  tok.token_type = jts_pkg::TT_COLON;
            default:   tok.token_type = jts_pkg::TT_COMMA;
          endcase
        end
        CH_QUOTE: begin
          mode_next  = MODE_STRING;
          begin_next = wrap_inc(scan_pos);
          len_next   = 16'd0;
          esc_next   = 1'b0;
        end
        CH_T, CH_F, CH_N: begin
          mode_next  = MODE_LITERAL;
          kind_next  = (scan_byte == CH_T) ? jts_pkg::KIND_TRUE :
                       (scan_byte == CH_F) ? jts_pkg::KIND_FALSE : jts_pkg::KIND_NULL;
          buf_we     = 1'b1;
          buf_waddr  = 2'd0;
          buf_wdata  = scan_byte;
          cnt_next   = 3'd1;
          begin_next = scan_pos;
        end
        default: begin
          if (scan_byte == CH_MINUS || (scan_byte >= CH_ZERO && scan_byte <= CH_NINE)) begin
            mode_next  = MODE_NUMBER;
            begin_next = scan_pos;
            len_next   = 16'd1;
            frac_next  = 1'b0;
          end else begin
            tok_emit        = 1'b1;
            tok.token_type  = jts_pkg::TT_ERROR;
            tok.token_start = to_start(scan_pos);
          end
        end
      endcase
    end
  end

  assign out_free = !token_valid || token_ready;

  always_comb begin
    status            = '0;
    status.hold       = pend_valid && !out_free;
    status.need_scan  = need_scan;
    status.fail_start = fail_start;
    status.fail_more  = fail_more;
    status.last       = last_reg;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode        <= MODE_IDLE;
      esc         <= 1'b0;
      frac        <= 1'b0;
      byte_offset <= '0;
      token_begin <= '0;
      tok_len     <= 16'd0;
      lit_kind    <= 2'd0;
      lit_cnt     <= 3'd0;
      pend_valid  <= 1'b0;
      token_valid <= 1'b0;
    end else begin
      mode        <= mode_next;
      esc         <= esc_next;
      frac        <= frac_next;
      byte_offset <= offset_next;
      token_begin <= begin_next;
      tok_len     <= len_next;
      lit_kind    <= kind_next;
      lit_cnt     <= cnt_next;

      // The controller only steps while a parked word can move on.
      if (tok_emit) begin
        if (pend_valid) begin
          token_data  <= {pend.token_type, pend.token_start, pend.token_length, 1'b0};
          token_valid <= 1'b1;
        end else if (token_valid && token_ready) begin
          token_valid <= 1'b0;
        end
        pend       <= tok;
        pend_valid <= 1'b1;
      end else if (release_pend && pend_valid) begin
        token_data  <= {pend.token_type, pend.token_start, pend.token_length, 1'b1};
        token_valid <= 1'b1;
        pend_valid  <= 1'b0;
      end else if (token_valid && token_ready) begin
        token_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    c_reg     <= c_next;
    last_reg  <= last_next;
    pos       <= pos_next;
    fail_base <= fail_base_next;
    fail_cnt  <= fail_cnt_next;
    fail_idx  <= fail_idx_next;
    if (buf_we) begin
      lit_buf[buf_waddr] <= buf_wdata;
    end
  end

endmodule

/* hdl/json_token_scanner_unit.sv */
// Streaming JSON lexer: one text byte in per handshake, tokens with type, start and
// length out. The sequencer in jts_ctrl walks each accepted byte through its latch and
// mode steps; a byte that breaks a literal also gets a rescan of the buffered literal
// bytes, one that ends a number or breaks a literal a scan from idle, and the final
// byte of a text the flush and the EOF word. A new byte is taken only once the last
// is done. The sequencer moves one scan step and at most one token word per cycle while
// the output is not stalled. Positions wrap at MAX_TEXT_BYTES and are reported modulo
// 65536. Depends on jts_pkg, jts_ctrl and jts_datapath.
module json_token_scanner_unit #(
  parameter int MAX_TEXT_BYTES = 65536
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                byte_valid,
  output logic                byte_ready,
  input  jts_pkg::in_word_t   byte_data,
  output logic                token_valid,
  input  logic                token_ready,
  output jts_pkg::out_word_t  token_data
);

  jts_pkg::cmd_t    cmd;
  jts_pkg::status_t status;

  jts_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .byte_valid (byte_valid),
    .byte_ready (byte_ready),
    .status     (status),
    .cmd        (cmd)
  );

  jts_datapath #(
    .MAX_TEXT_BYTES (MAX_TEXT_BYTES)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .status      (status),
    .byte_data   (byte_data),
    .token_valid (token_valid),
    .token_ready (token_ready),
    .token_data  (token_data)
  );

`ifndef ASSERT_OFF
  // No step may run while a parked word is blocked behind a full output register.
  a_no_step_on_hold: assert property (@(posedge clk) disable iff (rst)
    status.hold |-> (cmd == jts_pkg::CMD_NONE))
    else $error("scan step issued while token staging is blocked");

  // EOF is always the final word caused by its byte.
  a_eof_is_last: assert property (@(posedge clk) disable iff (rst)
    (token_valid && (token_data.token_type == jts_pkg::TT_EOF)) |-> token_data.token_last)
    else $error("EOF word not flagged as last");

  // Error and EOF words carry no text.
  a_zero_length: assert property (@(posedge clk) disable iff (rst)
    (token_valid && ((token_data.token_type == jts_pkg::TT_ERROR) ||
                     (token_data.token_type == jts_pkg::TT_EOF)))
    |-> (token_data.token_length == 16'd0))
    else $error("error or EOF word with nonzero length");
`endif

endmodule
